// ===== hw/rtl/f32_pkg.sv =====
package f32_pkg;

  localparam int unsigned QDEPTH = 2;
  localparam int unsigned QAW = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int unsigned QCW = $clog2(QDEPTH + 1);

  localparam logic [16:0] F32_MOD = 17'd65535;

  typedef struct packed {
    logic [15:0] word;
    logic        last;
  } word_item_t;

  typedef struct packed {
    logic push;
    logic have_low;
  } front_status_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

  // (a + b) mod 65535, a in 0..65534, b in 0..65535
  function automatic logic [15:0] mod_add(input logic [15:0] a, input logic [15:0] b);
    logic [16:0] s;
    s = {1'b0, a} + {1'b0, b};
    if (s >= F32_MOD) begin
      s = s - F32_MOD;
    end
    return s[15:0];
  endfunction

endpackage

// ===== hw/rtl/f32_front.sv =====
module f32_front (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  logic [7:0]             in_data_byte,
  input  logic                   in_last_byte,
  input  f32_pkg::q_status_t     q_status,
  output f32_pkg::word_item_t    push_item,
  output f32_pkg::front_status_t status
);

  logic [7:0] held_low_r;
  logic [7:0] held_low_nxt;
  logic       have_low_r;
  logic       have_low_nxt;
  logic       accept;

  assign in_ready = !q_status.full;
  assign accept   = in_valid && in_ready;

  always_comb begin
    held_low_nxt   = held_low_r;
    have_low_nxt   = have_low_r;
    status.push    = 1'b0;
    push_item.last = in_last_byte;
    push_item.word = have_low_r ? {in_data_byte, held_low_r} : {8'd0, in_data_byte};
    if (accept) begin
      if (have_low_r || in_last_byte) begin
        status.push  = 1'b1;
        have_low_nxt = 1'b0;
      end else begin
        held_low_nxt = in_data_byte;
        have_low_nxt = 1'b1;
      end
    end
    status.have_low = have_low_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      held_low_r <= 8'd0;
      have_low_r <= 1'b0;
    end else begin
      held_low_r <= held_low_nxt;
      have_low_r <= have_low_nxt;
    end
  end

endmodule

// ===== hw/rtl/f32_queue.sv =====
module f32_queue (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  input  f32_pkg::word_item_t push_item,
  input  logic                pop,
  output f32_pkg::word_item_t head_item,
  output f32_pkg::q_status_t  status
);

  f32_pkg::word_item_t       mem_r [f32_pkg::QDEPTH];
  logic [f32_pkg::QAW-1:0]   wr_ptr_r;
  logic [f32_pkg::QAW-1:0]   wr_ptr_nxt;
  logic [f32_pkg::QAW-1:0]   rd_ptr_r;
  logic [f32_pkg::QAW-1:0]   rd_ptr_nxt;
  logic [f32_pkg::QCW-1:0]   cnt_r;
  logic [f32_pkg::QCW-1:0]   cnt_nxt;
  logic                      do_push;
  logic                      do_pop;

  assign status.full  = (cnt_r == f32_pkg::QCW'(f32_pkg::QDEPTH));
  assign status.empty = (cnt_r == '0);
  assign do_push      = push && !status.full;
  assign do_pop       = pop && !status.empty;
  assign head_item    = mem_r[rd_ptr_r];

  function automatic logic [f32_pkg::QAW-1:0] ptr_inc(input logic [f32_pkg::QAW-1:0] p);
    logic [f32_pkg::QAW-1:0] r;
    if (p == f32_pkg::QAW'(f32_pkg::QDEPTH - 1)) begin
      r = '0;
    end else begin
      r = p + 1'b1;
    end
    return r;
  endfunction

  always_comb begin
    wr_ptr_nxt = do_push ? ptr_inc(wr_ptr_r) : wr_ptr_r;
    rd_ptr_nxt = do_pop ? ptr_inc(rd_ptr_r) : rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

endmodule

// ===== hw/rtl/f32_back.sv =====
module f32_back (
  input  logic                clk,
  input  logic                rst_n,
  input  f32_pkg::word_item_t head_item,
  input  f32_pkg::q_status_t  q_status,
  output logic                pop,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [31:0]         out_checksum
);

  logic [15:0] word_sum_r;
  logic [15:0] word_sum_nxt;
  logic [15:0] sum_of_sums_r;
  logic [15:0] sum_of_sums_nxt;
  logic [15:0] ws_upd;
  logic [15:0] sos_upd;
  logic        out_valid_r;
  logic        out_valid_nxt;
  logic [31:0] checksum_r;
  logic [31:0] checksum_nxt;

  assign ws_upd  = f32_pkg::mod_add(word_sum_r, head_item.word);
  assign sos_upd = f32_pkg::mod_add(sum_of_sums_r, ws_upd);
  assign pop     = !q_status.empty && (!head_item.last || !out_valid_r || out_ready);

  always_comb begin
    word_sum_nxt    = word_sum_r;
    sum_of_sums_nxt = sum_of_sums_r;
    checksum_nxt    = checksum_r;
    out_valid_nxt   = out_valid_r && !out_ready;
    if (pop) begin
      if (head_item.last) begin
        checksum_nxt    = {sos_upd, ws_upd};
        out_valid_nxt   = 1'b1;
        word_sum_nxt    = '0;
        sum_of_sums_nxt = '0;
      end else begin
        word_sum_nxt    = ws_upd;
        sum_of_sums_nxt = sos_upd;
      end
    end
  end

  always_ff @(posedge clk) begin
    checksum_r <= checksum_nxt;
    if (!rst_n) begin
      word_sum_r    <= '0;
      sum_of_sums_r <= '0;
      out_valid_r   <= 1'b0;
    end else begin
      word_sum_r    <= word_sum_nxt;
      sum_of_sums_r <= sum_of_sums_nxt;
      out_valid_r   <= out_valid_nxt;
    end
  end

  assign out_valid    = out_valid_r;
  assign out_checksum = checksum_r;

endmodule

// ===== hw/rtl/fletcher32_checksum_unit.sv =====
// fletcher-32 checksum over a byte stream
// input channel: in_valid/in_ready with in_data_byte and in_last_byte; one
//   message byte per item, in_last_byte marks the final byte of a message
// result channel: out_valid/out_ready with out_checksum, one item per message,
//   sum2 in bits 31:16 and sum1 in bits 15:0
// bytes pair into little-endian words in the front stage; a two-entry word
//   queue feeds the back stage, which folds one word per cycle into both sums
//   when one is queued, unless a last word waits on the busy output register
// throughput: one byte per cycle sustained while in_ready stays high
// out_valid rises once the last word is popped from the word queue
// reset: rst_n low clears the held byte, the queue, both sums and out_valid
// receiver stall: the result holds in the output register; words keep
//   folding until a next last word meets the busy output register, then the
//   queue fills and in_ready drops
module fletcher32_checksum_unit (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_data_byte,
  input  logic        in_last_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] out_checksum
);

  f32_pkg::word_item_t    push_item;
  f32_pkg::word_item_t    head_item;
  f32_pkg::front_status_t front_status;
  f32_pkg::q_status_t     q_status;
  logic                   pop;

  f32_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_data_byte (in_data_byte),
    .in_last_byte (in_last_byte),
    .q_status     (q_status),
    .push_item    (push_item),
    .status       (front_status)
  );

  f32_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (front_status.push),
    .push_item (push_item),
    .pop       (pop),
    .head_item (head_item),
    .status    (q_status)
  );

  f32_back u_back (
    .clk          (clk),
    .rst_n        (rst_n),
    .head_item    (head_item),
    .q_status     (q_status),
    .pop          (pop),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_checksum (out_checksum)
  );

  a_q_full_empty : assert property (@(posedge clk) disable iff (!rst_n)
    !(q_status.full && q_status.empty))
    else $error("queue reports full and empty together");

  a_lone_low_no_push : assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready && !in_last_byte && !front_status.have_low) |-> !front_status.push)
    else $error("word pushed before its high byte");

  a_last_clears_low : assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready && in_last_byte) |=> !front_status.have_low)
    else $error("held byte survives the end of a message");

  a_pop_needs_item : assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> !q_status.empty)
    else $error("back stage pops an empty queue");

endmodule

// ===== tb/testbench.sv =====
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [7:0]  data;
    logic        last;
    logic        known;
    logic [31:0] sum;
  } byte_row_t;

  localparam int NUM_ROWS = 22;
  localparam int RANDOM_BYTES = 1000;

  // directed stimulus: byte, last flag, checksum typed in when obvious
  localparam byte_row_t DIRECTED_ROWS [0:NUM_ROWS-1] = '{
    {8'h00, 1'b1, 1'b1, 32'h0000_0000},
    {8'hff, 1'b1, 1'b1, 32'h00ff_00ff},
    {8'hff, 1'b0, 1'b0, 32'h0000_0000},
    {8'hff, 1'b1, 1'b1, 32'h0000_0000},
    {8'h01, 1'b0, 1'b0, 32'h0000_0000},
    {8'h00, 1'b1, 1'b1, 32'h0001_0001},
    {8'hfe, 1'b0, 1'b0, 32'h0000_0000},
    {8'hff, 1'b1, 1'b1, 32'hfffe_fffe},
    {8'h01, 1'b0, 1'b0, 32'h0000_0000},
    {8'h02, 1'b0, 1'b0, 32'h0000_0000},
    {8'h03, 1'b1, 1'b0, 32'h0000_0000},
    {8'hfe, 1'b0, 1'b0, 32'h0000_0000},
    {8'hff, 1'b0, 1'b0, 32'h0000_0000},
    {8'hfe, 1'b0, 1'b0, 32'h0000_0000},
    {8'hff, 1'b1, 1'b0, 32'h0000_0000},
    {8'h00, 1'b0, 1'b0, 32'h0000_0000},
    {8'h80, 1'b1, 1'b1, 32'h8000_8000},
    {8'hff, 1'b0, 1'b0, 32'h0000_0000},
    {8'hff, 1'b0, 1'b0, 32'h0000_0000},
    {8'h55, 1'b0, 1'b0, 32'h0000_0000},
    {8'haa, 1'b0, 1'b0, 32'h0000_0000},
    {8'h7f, 1'b1, 1'b0, 32'h0000_0000}
  };

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [7:0]  in_data_byte = 8'h00;
  logic        in_last_byte = 1'b0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [31:0] out_checksum;

  // table checksum travelling with the item on the input channel
  logic        row_known = 1'b0;
  logic [31:0] row_sum = 32'h0;

  // checksum predictor state
  logic [7:0]  held_low = 8'h00;
  logic        have_low = 1'b0;
  logic [15:0] word_sum = 16'h0000;
  logic [15:0] sum_of_sums = 16'h0000;

  logic [31:0] pending_checksums[$];
  int          mismatches = 0;
  int          bytes_seen = 0;
  int          checksums_seen = 0;
  logic        sender_burst = 1'b0;

  fletcher32_checksum_unit DUT (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_data_byte (in_data_byte),
    .in_last_byte (in_last_byte),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_checksum (out_checksum)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic logic [15:0] add_mod65535(input logic [15:0] a, input logic [15:0] b);
    logic [16:0] s;
    s = {1'b0, a} + {1'b0, b};
    if (s >= 17'd65535) begin
      s = s - 17'd65535;
    end
    return s[15:0];
  endfunction

  task automatic fold_word(input logic [15:0] w);
    word_sum = add_mod65535(word_sum, w);
    sum_of_sums = add_mod65535(sum_of_sums, word_sum);
  endtask

  task automatic clear_sums();
    held_low = 8'h00;
    have_low = 1'b0;
    word_sum = 16'h0000;
    sum_of_sums = 16'h0000;
  endtask

  task automatic note_mismatch(input string msg);
    mismatches++;
    if (mismatches <= 10) begin
      $display("mismatch at %0t: %s", $time, msg);
    end
  endtask

  function automatic int pick_gap(input logic no_idle);
    int r;
    if (no_idle) begin
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 60) begin
      return 0;
    end else if (r < 90) begin
      return $urandom_range(1, 3);
    end else if (r < 98) begin
      return $urandom_range(4, 10);
    end
    return $urandom_range(20, 60);
  endfunction

  always @(posedge clk) begin
    logic [31:0] want;
    if (!rst_n) begin
      clear_sums();
    end else begin
      if (out_valid && out_ready) begin
        if (pending_checksums.size() == 0) begin
          note_mismatch($sformatf("checksum %h with none expected", out_checksum));
        end else begin
          want = pending_checksums.pop_front();
          checksums_seen++;
          if (out_checksum !== want) begin
            note_mismatch($sformatf("checksum expected %h got %h", want, out_checksum));
          end
        end
      end
      if (in_valid && in_ready) begin
        bytes_seen++;
        if (have_low) begin
          fold_word({in_data_byte, held_low});
          have_low = 1'b0;
          held_low = 8'h00;
        end else if (in_last_byte) begin
          fold_word({8'h00, in_data_byte});
        end else begin
          held_low = in_data_byte;
          have_low = 1'b1;
        end
        if (in_last_byte) begin
          pending_checksums.push_back(row_known ? row_sum : {sum_of_sums, word_sum});
          clear_sums();
        end
      end
    end
  end

  task automatic send_byte(input logic [7:0] b, input logic l, input logic known,
                           input logic [31:0] sum);
    int g;
    g = pick_gap(sender_burst);
    if (g > 0) begin
      in_valid <= 1'b0;
      repeat (g) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data_byte <= b;
    in_last_byte <= l;
    row_known <= known;
    row_sum <= sum;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  task automatic wait_for_checksums();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_checksums.size() != 0) @(posedge clk);
  endtask

  // result side: ready stretches broken by random stalls
  initial begin
    int hold;
    int g;
    wait (rst_n === 1'b1);
    forever begin
      out_ready <= 1'b1;
      hold = $urandom_range(1, 24);
      if ($urandom_range(0, 9) == 0) begin
        hold = $urandom_range(50, 200);
      end
      repeat (hold) @(posedge clk);
      g = pick_gap(1'b0);
      if (g > 0) begin
        out_ready <= 1'b0;
        repeat (g) @(posedge clk);
      end
    end
  end

  initial begin
    int sent;
    int msg;
    int len;
    int style;
    logic [7:0] b;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    for (int i = 0; i < NUM_ROWS; i++) begin
      send_byte(DIRECTED_ROWS[i].data, DIRECTED_ROWS[i].last, DIRECTED_ROWS[i].known,
                DIRECTED_ROWS[i].sum);
    end

    sent = 0;
    msg = 0;
    while (sent < RANDOM_BYTES) begin
      if ($urandom_range(0, 4) == 0) begin
        sender_burst = ~sender_burst;
      end
      style = $urandom_range(0, 99);
      if (style < 70) begin
        len = $urandom_range(1, 8);
      end else if (style < 95) begin
        len = $urandom_range(9, 40);
      end else begin
        len = $urandom_range(100, 300);
      end
      if (len > RANDOM_BYTES - sent) begin
        len = RANDOM_BYTES - sent;
      end
      style = $urandom_range(0, 9);
      for (int i = 0; i < len; i++) begin
        case (style)
          0: b = 8'hff;
          1: b = $urandom_range(0, 1) ? 8'hff : 8'hfe;
          2: b = 8'h00;
          default: begin
            b = 8'($urandom_range(0, 255));
            if ($urandom_range(0, 7) == 0) begin
              b = $urandom_range(0, 1) ? 8'hff : 8'h00;
            end
          end
        endcase
        send_byte(b, (i == len - 1), 1'b0, 32'h0);
        sent++;
      end
      msg++;
      if (msg == 25 || $urandom_range(0, 39) == 0) begin
        wait_for_checksums();
      end
    end

    wait_for_checksums();
    repeat (10) @(posedge clk);
    $display("%0d bytes sent, %0d checksums compared, %0d mismatches", bytes_seen,
             checksums_seen, mismatches);
    $display("messages of 1 to 300 bytes, odd and even lengths, stalls on both channels");
    if (mismatches == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("timeout with %0d checksums outstanding", pending_checksums.size());
    $display("== FAIL ==");
    $finish;
  end

endmodule

// ===== files.f =====
hw/rtl/f32_pkg.sv
hw/rtl/f32_front.sv
hw/rtl/f32_queue.sv
hw/rtl/f32_back.sv
hw/rtl/fletcher32_checksum_unit.sv
tb/testbench.sv
